@@ rtl/assert_macros.svh @@
// assertion macros shared by the allocator modules
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define FLAS_ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define FLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define FLAS_ASSERT_SAME(label, clk, rst_n, ante, cons)
`define FLAS_ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

@@ rtl/flas_pkg.sv @@
// shared types and constants of the free list allocator
`default_nettype none

package flas_pkg;

    localparam int ENTRIES_DEF = 512;
    localparam int IDX_W       = 9;
    localparam int FREE_W      = 10;

    typedef enum logic [1:0] {
        CMD_ALLOC = 2'd0,
        CMD_FREE  = 2'd1,
        CMD_MARK  = 2'd2,
        CMD_SWEEP = 2'd3
    } t_cmd;

    typedef enum logic [3:0] {
        OP_NONE,
        OP_INIT,
        OP_ALLOC,
        OP_ALLOC_TAKE,
        OP_FREE,
        OP_MARK,
        OP_SWEEP_START,
        OP_SWEEP_STEP,
        OP_SWEEP_END
    } t_op;

    typedef struct packed {
        t_op  op;
        logic load_out;
    } t_ctl;

    typedef struct packed {
        logic init_last;
        logic sweep_last;
        logic empty;
    } t_sts;

endpackage

`default_nettype wire

@@ rtl/flas_cmd_if.sv @@
// command channel interface
`default_nettype none

interface flas_cmd_if;
    logic                               valid;
    logic                               ready;
    flas_pkg::t_cmd                     cmd;
    logic [flas_pkg::IDX_W-1:0]         entry_index;

    modport source (output valid, output cmd, output entry_index, input ready);
    modport sink   (input valid, input cmd, input entry_index, output ready);
endinterface

`default_nettype wire

@@ rtl/flas_rsp_if.sv @@
// response channel interface
`default_nettype none

interface flas_rsp_if;
    logic                               valid;
    logic                               ready;
    logic [flas_pkg::IDX_W-1:0]         granted_index;
    logic                               status;
    logic [flas_pkg::FREE_W-1:0]        free_entries;

    modport source (output valid, output granted_index, output status,
                    output free_entries, input ready);
    modport sink   (input valid, input granted_index, input status,
                    input free_entries, output ready);
endinterface

`default_nettype wire

@@ rtl/free_list_allocator_with_sweep.sv @@
// top level of the free list allocator with mark and sweep
//
//   channel   dir  payload                                  handshake
//   i_cmd     in   cmd, entry_index                         valid / ready
//   o_rsp     out  granted_index, status, free_entries      valid / ready
//
// after reset a clearing pass rebuilds the link chain and clears the marks,
// writing each entry in turn with ready low
// free and mark pass through the finish state, alloc also through a read state
// (one registered read of the link memory), a refused alloc straight to finish
// a sweep walks one entry per cycle through the mark memory
// one item at a time; a result waits in the output register while the next
// item is taken, and a stalled output holds the block in its finish state
`default_nettype none

module free_list_allocator_with_sweep #(
    parameter int ENTRIES = flas_pkg::ENTRIES_DEF
) (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    flas_cmd_if.sink    i_cmd,
    flas_rsp_if.source  o_rsp
);
    import flas_pkg::*;

    t_ctl ctl;
    t_sts sts;

    flas_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_cmd.valid),
        .i_cmd       (i_cmd.cmd),
        .i_sts       (sts),
        .i_out_ready (o_rsp.ready),
        .o_in_ready  (i_cmd.ready),
        .o_out_valid (o_rsp.valid),
        .o_ctl       (ctl)
    );

    flas_dp #(.ENTRIES(ENTRIES)) u_dp (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_idx     (i_cmd.entry_index),
        .i_ctl     (ctl),
        .o_sts     (sts),
        .o_granted (o_rsp.granted_index),
        .o_status  (o_rsp.status),
        .o_free    (o_rsp.free_entries)
    );

endmodule

`default_nettype wire

@@ rtl/flas_ram.sv @@
// generic simple dual port ram with registered read
`default_nettype none

module flas_ram #(
    parameter int WIDTH = 1,
    parameter int DEPTH = 2,
    localparam int AW   = $clog2(DEPTH)
) (
    input  wire logic             i_clk,
    input  wire logic             i_we,
    input  wire logic [AW-1:0]    i_waddr,
    input  wire logic [WIDTH-1:0] i_wdata,
    input  wire logic [AW-1:0]    i_raddr,
    output logic      [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

@@ rtl/flas_ctrl.sv @@
// controller state machine of the allocator
`default_nettype none
`include "assert_macros.svh"

module flas_ctrl (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_in_valid,
    input  wire flas_pkg::t_cmd i_cmd,
    input  wire flas_pkg::t_sts i_sts,
    input  wire logic           i_out_ready,
    output logic                o_in_ready,
    output logic                o_out_valid,
    output flas_pkg::t_ctl      o_ctl
);
    import flas_pkg::*;

    typedef enum logic [2:0] {
        ST_INIT,
        ST_IDLE,
        ST_ALLOC_RD,
        ST_SWEEP,
        ST_SWEEP_LAST,
        ST_FINISH
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   r_out_valid;
    logic   accept;
    t_ctl   ctl;

    assign o_in_ready = (r_state == ST_IDLE);
    assign accept     = i_in_valid && o_in_ready;

    always_comb begin
        n_state      = r_state;
        ctl.op       = OP_NONE;
        ctl.load_out = 1'b0;
        unique case (r_state)
            ST_INIT: begin
                ctl.op = OP_INIT;
                if (i_sts.init_last) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (accept) begin
                    unique case (i_cmd)
                        CMD_ALLOC: begin
                            ctl.op  = OP_ALLOC;
                            n_state = i_sts.empty ? ST_FINISH : ST_ALLOC_RD;
                        end
                        CMD_FREE: begin
                            ctl.op  = OP_FREE;
                            n_state = ST_FINISH;
                        end
                        CMD_MARK: begin
                            ctl.op  = OP_MARK;
                            n_state = ST_FINISH;
                        end
                        CMD_SWEEP: begin
                            ctl.op  = OP_SWEEP_START;
                            n_state = ST_SWEEP;
                        end
                        default: begin
                            n_state = ST_IDLE;
                        end
                    endcase
                end
            end
            ST_ALLOC_RD: begin
                ctl.op  = OP_ALLOC_TAKE;
                n_state = ST_FINISH;
            end
            ST_SWEEP: begin
                ctl.op = OP_SWEEP_STEP;
                if (i_sts.sweep_last) begin
                    n_state = ST_SWEEP_LAST;
                end
            end
            ST_SWEEP_LAST: begin
                ctl.op  = OP_SWEEP_END;
                n_state = ST_FINISH;
            end
            ST_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    ctl.load_out = 1'b1;
                    n_state      = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_INIT;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (ctl.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_ctl       = ctl;

    `FLAS_ASSERT_NEXT(a_sweep_enter, i_clk, i_rst_n, accept && (i_cmd == CMD_SWEEP), r_state == ST_SWEEP)
    `FLAS_ASSERT_NEXT(a_finish_loads, i_clk, i_rst_n, ctl.load_out, r_out_valid && (r_state == ST_IDLE))
    `FLAS_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, r_out_valid && !i_out_ready, r_out_valid)

endmodule

`default_nettype wire

@@ rtl/flas_dp.sv @@
// datapath of the allocator: head, count, sweep walk and the two memories
`default_nettype none
`include "assert_macros.svh"

module flas_dp #(
    parameter int ENTRIES = flas_pkg::ENTRIES_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic [flas_pkg::IDX_W-1:0]    i_idx,
    input  wire flas_pkg::t_ctl                i_ctl,
    output flas_pkg::t_sts                     o_sts,
    output logic      [flas_pkg::IDX_W-1:0]    o_granted,
    output logic                               o_status,
    output logic      [flas_pkg::FREE_W-1:0]   o_free
);
    import flas_pkg::*;

    localparam int IW = $clog2(ENTRIES);
    localparam int CW = $clog2(ENTRIES + 1);
    localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);
    localparam logic [IW-1:0] PRE_LAST = IW'(ENTRIES - 2);
    localparam logic [CW-1:0] FULL = CW'(ENTRIES);

    logic [IW-1:0]     r_ptr, n_ptr;
    logic [IW-1:0]     r_prev, n_prev;
    logic [IW-1:0]     r_head, n_head;
    logic [CW-1:0]     r_count, n_count;
    logic [IW-1:0]     r_sw_head, n_sw_head;
    logic [CW-1:0]     r_sw_cnt, n_sw_cnt;
    logic [IW-1:0]     r_granted, n_granted;
    logic              r_status, n_status;
    logic [IDX_W-1:0]  r_o_granted;
    logic              r_o_status;
    logic [FREE_W-1:0] r_o_free;

    logic              link_we;
    logic [IW-1:0]     link_waddr;
    logic [IW-1:0]     link_wdata;
    logic [IW-1:0]     link_raddr;
    logic [IW-1:0]     link_rdata;
    logic              mark_we;
    logic [IW-1:0]     mark_waddr;
    logic              mark_wdata;
    logic [IW-1:0]     mark_raddr;
    logic              mark_rdata;

    logic [IW-1:0]     idx_w;
    logic              idx_ok;
    logic              unmarked;
    logic              init_last;

    assign idx_w     = IW'(i_idx);
    assign idx_ok    = (32'(i_idx) < 32'(ENTRIES));
    assign unmarked  = ~mark_rdata;
    assign init_last = (r_ptr == LAST);

    flas_ram #(.WIDTH(IW), .DEPTH(ENTRIES)) u_link_ram (
        .i_clk   (i_clk),
        .i_we    (link_we),
        .i_waddr (link_waddr),
        .i_wdata (link_wdata),
        .i_raddr (link_raddr),
        .o_rdata (link_rdata)
    );

    flas_ram #(.WIDTH(1), .DEPTH(ENTRIES)) u_mark_ram (
        .i_clk   (i_clk),
        .i_we    (mark_we),
        .i_waddr (mark_waddr),
        .i_wdata (mark_wdata),
        .i_raddr (mark_raddr),
        .o_rdata (mark_rdata)
    );

    always_comb begin
        link_we    = 1'b0;
        link_waddr = r_ptr;
        link_wdata = '0;
        link_raddr = r_head;
        mark_we    = 1'b0;
        mark_waddr = r_ptr;
        mark_wdata = 1'b0;
        mark_raddr = r_ptr;

        n_ptr      = r_ptr;
        n_prev     = r_prev;
        n_head     = r_head;
        n_count    = r_count;
        n_sw_head  = r_sw_head;
        n_sw_cnt   = r_sw_cnt;
        n_granted  = r_granted;
        n_status   = r_status;

        unique case (i_ctl.op)
            OP_INIT: begin
                link_we    = 1'b1;
                link_wdata = init_last ? '0 : r_ptr + IW'(1);
                mark_we    = 1'b1;
                n_ptr      = r_ptr + IW'(1);
            end
            OP_ALLOC: begin
                if (r_count == '0) begin
                    n_granted = '0;
                    n_status  = 1'b1;
                end else begin
                    n_granted = r_head;
                    n_status  = 1'b0;
                    n_count   = r_count - CW'(1);
                end
            end
            OP_ALLOC_TAKE: begin
                n_head = link_rdata;
            end
            OP_FREE: begin
                n_granted = '0;
                n_status  = 1'b0;
                if (idx_ok) begin
                    link_we    = 1'b1;
                    link_waddr = idx_w;
                    link_wdata = r_head;
                    n_head     = idx_w;
                    if (r_count != FULL) begin
                        n_count = r_count + CW'(1);
                    end
                end
            end
            OP_MARK: begin
                n_granted = '0;
                n_status  = 1'b0;
                if (idx_ok) begin
                    mark_we    = 1'b1;
                    mark_waddr = idx_w;
                    mark_wdata = 1'b1;
                end
            end
            OP_SWEEP_START: begin
                n_granted  = '0;
                n_status   = 1'b0;
                mark_raddr = LAST;
                n_prev     = LAST;
                n_ptr      = PRE_LAST;
                n_sw_head  = '0;
                n_sw_cnt   = '0;
            end
            OP_SWEEP_STEP: begin
                mark_we    = 1'b1;
                mark_waddr = r_prev;
                link_we    = unmarked;
                link_waddr = r_prev;
                link_wdata = r_sw_head;
                if (unmarked) begin
                    n_sw_head = r_prev;
                    n_sw_cnt  = r_sw_cnt + CW'(1);
                end
                n_prev = r_ptr;
                n_ptr  = r_ptr - IW'(1);
            end
            OP_SWEEP_END: begin
                mark_we    = 1'b1;
                mark_waddr = r_prev;
                link_we    = unmarked;
                link_waddr = r_prev;
                link_wdata = r_sw_head;
                n_head     = unmarked ? r_prev : r_sw_head;
                n_count    = r_sw_cnt + CW'(unmarked);
            end
            default: begin
                n_ptr = r_ptr;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ptr   <= '0;
            r_head  <= '0;
            r_count <= FULL;
        end else begin
            r_ptr   <= n_ptr;
            r_head  <= n_head;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        r_prev    <= n_prev;
        r_sw_head <= n_sw_head;
        r_sw_cnt  <= n_sw_cnt;
        r_granted <= n_granted;
        r_status  <= n_status;
        if (i_ctl.load_out) begin
            r_o_granted <= IDX_W'(r_granted);
            r_o_status  <= r_status;
            r_o_free    <= FREE_W'(r_count);
        end
    end

    assign o_sts.init_last  = init_last;
    assign o_sts.sweep_last = (r_ptr == '0);
    assign o_sts.empty      = (r_count == '0);
    assign o_granted        = r_o_granted;
    assign o_status         = r_o_status;
    assign o_free           = r_o_free;

    `FLAS_ASSERT_SAME(a_count_range, i_clk, i_rst_n, 1'b1, r_count <= FULL)
    `FLAS_ASSERT_NEXT(a_alloc_dec, i_clk, i_rst_n, (i_ctl.op == OP_ALLOC) && (r_count != '0), r_count == $past(r_count) - CW'(1))
    `FLAS_ASSERT_NEXT(a_free_head, i_clk, i_rst_n, (i_ctl.op == OP_FREE) && idx_ok, r_head == $past(idx_w))

endmodule

`default_nettype wire
